// File: sv/stdp_weight_update_defines.svh
// ----------------------------------------------------------------------------
// stdp weight update assertion macros
// shared concurrent assertion forms for the stdp weight update rtl
// ----------------------------------------------------------------------------
`ifndef STDP_WEIGHT_UPDATE_DEFINES_SVH
`define STDP_WEIGHT_UPDATE_DEFINES_SVH

// checked only while out of reset
`define STDP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define STDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/stdp_pkg.sv
// ----------------------------------------------------------------------------
// stdp package
// widths, exp tables, register codes and stage payload types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stdp_pkg;

    localparam int ExpEntries  = 256;
    localparam int IdxW        = $clog2(ExpEntries);
    localparam int FracBits    = 20;
    localparam int SW          = FracBits + IdxW;
    localparam int IntEntries  = 16;
    localparam int WindowTicks = 1600;
    localparam int AdW         = 11;
    localparam int XW          = AdW + 16;
    localparam int WeightMax   = 40960;

    localparam logic [15:0] RstPotGain = 16'd655;
    localparam logic [15:0] RstDepGain = 16'd786;
    localparam logic [15:0] RstInvTauP = 16'd3277;
    localparam logic [15:0] RstInvTauD = 16'd3277;

    typedef enum logic [1:0] {
        CfgPotGain = 2'd0,
        CfgDepGain = 2'd1,
        CfgInvTauP = 2'd2,
        CfgInvTauD = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] pot_gain;
        logic [15:0] dep_gain;
        logic [15:0] inv_tau_p;
        logic [15:0] inv_tau_d;
    } t_cfg;

    typedef struct packed {
        logic [15:0] weight;
        logic [15:0] step;
        logic        pot;
    } t_side;

    typedef struct packed {
        logic [XW-1:0] x;
        logic          in_win;
        t_side         side;
    } t_dlt;

    typedef struct packed {
        logic [16:0] e16;
        t_side       side;
    } t_exp;

    typedef logic [30:0] t_q30;
    typedef t_q30 t_frac_tab [ExpEntries];
    typedef t_q30 t_int_tab [IntEntries];

    // exp(-t), t in q2.30 up to 1.0, truncating taylor series
    function automatic logic [63:0] exp_neg_series(input logic [63:0] t);
        logic signed [63:0] sum;
        logic [63:0]        term;
        sum  = 64'sd1 <<< 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * t) >> 30) / 64'(k);
            if (k % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        return (sum < 0) ? 64'd0 : 64'(sum);
    endfunction

    function automatic t_frac_tab build_frac(input int off);
        t_frac_tab tab;
        for (int i = 0; i < ExpEntries; i++) begin
            tab[i] = t_q30'(exp_neg_series((64'(i + off) << 30) / ExpEntries));
        end
        return tab;
    endfunction

    function automatic t_int_tab build_int();
        t_int_tab    tab;
        logic [63:0] e1;
        e1     = exp_neg_series(64'd1 << 30);
        tab[0] = t_q30'(64'd1 << 30);
        for (int i = 1; i < IntEntries; i++) begin
            tab[i] = t_q30'((64'(tab[i - 1]) * e1) >> 30);
        end
        return tab;
    endfunction

    // lower and upper neighbor of each interpolation interval
    localparam t_frac_tab FracLo = build_frac(0);
    localparam t_frac_tab FracHi = build_frac(1);
    localparam t_int_tab  IntTab = build_int();

endpackage

// File: sv/stdp_delta.sv
// ----------------------------------------------------------------------------
// stdp delta stages
// spike time difference, window test and scaled exp argument
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stdp_delta import stdp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_weight,
    input  logic [31:0] i_pre,
    input  logic [31:0] i_post,
    input  logic [15:0] i_step,
    output logic        o_valid,
    input  logic        i_ready,
    output t_dlt        o_data
);

    logic        r_v1, r_v2;
    logic        w_en1, w_en2;
    logic [32:0] w_fwd;
    logic [31:0] n_ad, r_ad;
    logic        n_pot;
    t_side       r_side1;
    logic [15:0] w_inv;
    t_dlt        n_dlt, r_dlt;

    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_comb begin
        w_fwd = {1'b0, i_post} - {1'b0, i_pre};
        n_ad  = w_fwd[32] ? (i_pre - i_post) : w_fwd[31:0];
        n_pot = !w_fwd[32] && (|w_fwd[31:0]);
    end

    always_comb begin
        w_inv        = r_side1.pot ? i_cfg.inv_tau_p : i_cfg.inv_tau_d;
        n_dlt.in_win = (r_ad < 32'(WindowTicks));
        n_dlt.x      = XW'(r_ad[AdW-1:0]) * XW'(w_inv);
        n_dlt.side   = r_side1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_ad           <= n_ad;
            r_side1.weight <= i_weight;
            r_side1.step   <= i_step;
            r_side1.pot    <= n_pot;
        end
        if (w_en2) begin
            r_dlt <= n_dlt;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_dlt;

endmodule

// File: sv/stdp_exp.sv
// ----------------------------------------------------------------------------
// stdp exp stages
// table based exp(-x) with linear interpolation, rounded to q.16
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stdp_exp import stdp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_dlt i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_exp o_data
);

    logic [5:0] r_vld;
    logic [5:0] w_en;

    // stage 3: table lookup
    logic [SW-1:0]       w_s;
    logic [IdxW-1:0]     w_idx;
    t_q30                r3_a, r3_b;
    logic [FracBits-1:0] r3_r;
    logic [3:0]          r3_n;
    logic                r3_zero;
    t_side               r3_side;

    // stage 4: neighbor difference
    t_q30                r4_a, r4_diff;
    logic                r4_sub;
    logic [FracBits-1:0] r4_r;
    logic [3:0]          r4_n;
    logic                r4_zero;
    t_side               r4_side;

    // stage 5: interpolation product
    logic [50:0]         w_prod;
    t_q30                r5_a, r5_corr;
    logic                r5_sub;
    logic [3:0]          r5_n;
    logic                r5_zero;
    t_side               r5_side;

    // stage 6: fractional exp
    t_q30                r6_fv;
    logic [3:0]          r6_n;
    logic                r6_zero;
    t_side               r6_side;

    // stage 7: integer part product
    logic [61:0]         w_e;
    t_q30                r7_e30;
    logic                r7_zero;
    t_side               r7_side;

    // stage 8: rounding
    logic [30:0]         w_rnd;
    t_exp                r8_out;

    always_comb begin
        w_en[5] = !r_vld[5] || i_ready;
        for (int k = 4; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k + 1];
        end
    end

    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < 6; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k - 1];
            end
        end
    end

    assign w_s    = SW'(i_data.x[FracBits-1:0]) * SW'(ExpEntries);
    assign w_idx  = w_s[SW-1 -: IdxW];
    assign w_prod = 51'(r4_diff) * 51'(r4_r);
    assign w_e    = 62'(IntTab[r6_n]) * 62'(r6_fv);
    assign w_rnd  = r7_e30 + 31'd8192;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r3_a    <= FracLo[w_idx];
            r3_b    <= FracHi[w_idx];
            r3_r    <= w_s[FracBits-1:0];
            r3_n    <= i_data.x[FracBits +: 4];
            r3_zero <= !i_data.in_win || (|i_data.x[XW-1:FracBits+4]);
            r3_side <= i_data.side;
        end
        if (w_en[1]) begin
            r4_a    <= r3_a;
            r4_sub  <= (r3_a >= r3_b);
            r4_diff <= (r3_a >= r3_b) ? (r3_a - r3_b) : (r3_b - r3_a);
            r4_r    <= r3_r;
            r4_n    <= r3_n;
            r4_zero <= r3_zero;
            r4_side <= r3_side;
        end
        if (w_en[2]) begin
            r5_a    <= r4_a;
            r5_corr <= w_prod[FracBits +: 31];
            r5_sub  <= r4_sub;
            r5_n    <= r4_n;
            r5_zero <= r4_zero;
            r5_side <= r4_side;
        end
        if (w_en[3]) begin
            r6_fv   <= r5_sub ? (r5_a - r5_corr) : (r5_a + r5_corr);
            r6_n    <= r5_n;
            r6_zero <= r5_zero;
            r6_side <= r5_side;
        end
        if (w_en[4]) begin
            r7_e30  <= w_e[60:30];
            r7_zero <= r6_zero;
            r7_side <= r6_side;
        end
        if (w_en[5]) begin
            r8_out.e16  <= r7_zero ? 17'd0 : w_rnd[30:14];
            r8_out.side <= r7_side;
        end
    end

    assign o_valid = r_vld[5];
    assign o_data  = r8_out;

endmodule

// File: sv/stdp_scale.sv
// ----------------------------------------------------------------------------
// stdp scale stages
// gain and step scaling, weight update and saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stdp_scale import stdp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_exp        i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_weight
);

    logic [2:0]  r_vld;
    logic [2:0]  w_en;
    logic [15:0] w_gain;
    logic [32:0] r_p1;
    t_side       r_side1;
    logic [48:0] r_p2;
    t_side       r_side2;
    logic [48:0] w_rnd;
    logic [22:0] w_mag;
    logic signed [22:0] w_sum;
    logic [15:0] n_weight, r_weight;

    assign w_en[2] = !r_vld[2] || i_ready;
    assign w_en[1] = !r_vld[1] || w_en[2];
    assign w_en[0] = !r_vld[0] || w_en[1];
    assign o_ready = w_en[0];

    assign w_gain = i_data.side.pot ? i_cfg.pot_gain : i_cfg.dep_gain;

    always_comb begin
        w_rnd = r_p2 + 49'(1 << 27);
        w_mag = 23'(w_rnd[48:28]);
        if (r_side2.pot) begin
            w_sum = $signed(23'(r_side2.weight)) + $signed(w_mag);
        end else begin
            w_sum = $signed(23'(r_side2.weight)) - $signed(w_mag);
        end
        if (w_sum < 0) begin
            n_weight = 16'd0;
        end else if (w_sum > 23'sd40960) begin
            n_weight = 16'(WeightMax);
        end else begin
            n_weight = w_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_p1    <= 33'(w_gain) * 33'(i_data.e16);
            r_side1 <= i_data.side;
        end
        if (w_en[1]) begin
            r_p2    <= 49'(r_p1) * 49'(r_side1.step);
            r_side2 <= r_side1;
        end
        if (w_en[2]) begin
            r_weight <= n_weight;
        end
    end

    assign o_valid  = r_vld[2];
    assign o_weight = r_weight;

endmodule

// File: sv/stdp_weight_update.sv
// ----------------------------------------------------------------------------
// stdp weight update
// pair based stdp synapse update with an exponential timing window
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_ready carry weight, pre and post spike
//   times and step factor; a transfer happens when both are high.
//   output channel: o_out_valid / i_out_ready carry the updated weight.
//   config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; always ready, write only while no item is in flight.
//   pipeline: an input transfer reaches o_out_valid through the eleven
//   register stages (delta 2, exp 6, scale 3).
//   throughput: one item per cycle while the receiver keeps up; every stage
//   has its own valid bit and loads when it is empty or its successor moves.
//   receiver stall: the result holds in the output register, earlier
//   stages keep filling empty slots, and o_in_ready drops only once all
//   eleven stages hold items.
//   reset: synchronous, clears all stage valid bits and loads the default
//   gains and time constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stdp_weight_update_defines.svh"

module stdp_weight_update import stdp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_weight_in,
    input  logic [31:0] i_pre_time,
    input  logic [31:0] i_post_time,
    input  logic [15:0] i_step_factor,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_weight_out
);

    t_cfg r_cfg;
    logic w_dlt_valid, w_dlt_ready;
    t_dlt w_dlt;
    logic w_exp_valid, w_exp_ready;
    t_exp w_exp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pot_gain  <= RstPotGain;
            r_cfg.dep_gain  <= RstDepGain;
            r_cfg.inv_tau_p <= RstInvTauP;
            r_cfg.inv_tau_d <= RstInvTauD;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CfgPotGain: r_cfg.pot_gain  <= i_cfg_data;
                CfgDepGain: r_cfg.dep_gain  <= i_cfg_data;
                CfgInvTauP: r_cfg.inv_tau_p <= i_cfg_data;
                CfgInvTauD: r_cfg.inv_tau_d <= i_cfg_data;
                default:    r_cfg           <= r_cfg;
            endcase
        end
    end

    stdp_delta u_delta (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_weight (i_weight_in),
        .i_pre    (i_pre_time),
        .i_post   (i_post_time),
        .i_step   (i_step_factor),
        .o_valid  (w_dlt_valid),
        .i_ready  (w_dlt_ready),
        .o_data   (w_dlt)
    );

    stdp_exp u_exp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_dlt_valid),
        .o_ready  (w_dlt_ready),
        .i_data   (w_dlt),
        .o_valid  (w_exp_valid),
        .i_ready  (w_exp_ready),
        .o_data   (w_exp)
    );

    stdp_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_exp_valid),
        .o_ready  (w_exp_ready),
        .i_data   (w_exp),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_weight (o_weight_out)
    );

    // saturation keeps the weight in range
    `STDP_ASSERT(a_weight_range, i_clk, i_rst_n, o_out_valid |-> (o_weight_out <= 16'd40960), "weight out of range")

    // input backpressure only when the whole pipe is full and the output stalls
    `STDP_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_in_ready |-> (o_out_valid && !i_out_ready), "input stalled without output stall")

    // reset empties the pipe
    `STDP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule
